>>> rtl/bbs_pkg.sv
package bbs_pkg;

   // Default modulus width and the fixed width of the state_value result field
   localparam int MODULUS_WIDTH_DEFAULT = 32;
   localparam int STATE_VALUE_WIDTH     = 32;

   // Configuration register indexes
   localparam int CSR_INDEX_WIDTH = 1;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;
   localparam csr_index_type CSR_MODULUS = 1'b0;
   localparam csr_index_type CSR_SEED    = 1'b1;

   // Reset value of the modulus register
   localparam int MODULUS_RESET = 3;

   // Controller to datapath commands
   typedef struct packed {
      logic sel_seed;   // square the seed instead of the stored state
      logic mul;        // capture the square, clear remainder and step count
      logic red_step;   // one shift-subtract step of the reduction
      logic write_cur;  // store the reduced value as the new state
      logic out_load;   // load the result register
   } bbs_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic red_last;   // the current reduction step is the final one
   } bbs_status_type;

endpackage

>>> rtl/bbs_req_if.sv
interface bbs_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

>>> rtl/bbs_rsp_if.sv
interface bbs_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  random_bit;
   logic [bbs_pkg::STATE_VALUE_WIDTH-1:0] state_value;

   modport source (output valid, output random_bit, output state_value, input ready);
   modport sink   (input valid, input random_bit, input state_value, output ready);
endinterface

>>> rtl/bbs_ctrl.sv
module bbs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_restart,
   output logic                    req_ready,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output bbs_pkg::bbs_cmd_type    cmd,
   input  bbs_pkg::bbs_status_type status
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_RED  = 4'b0100,
      ST_FIN  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      two_pass_ff, two_pass_in;
   logic      seeded_ff, seeded_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      two_pass_in  = two_pass_ff;
      seeded_in    = seeded_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // reload from the seed on restart or on the first item after reset
               two_pass_in = req_restart || !seeded_ff;
               seeded_in   = 1'b1;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul      = 1'b1;
            cmd.sel_seed = two_pass_ff;
            state_in     = ST_RED;
         end
         ST_RED: begin
            cmd.red_step = 1'b1;
            if (status.red_last) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.write_cur = 1'b1;
            if (two_pass_ff) begin
               two_pass_in = 1'b0;
               state_in    = ST_MUL;
            end else if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         two_pass_ff  <= 1'b0;
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         two_pass_ff  <= two_pass_in;
         seeded_ff    <= seeded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/bbs_datapath.sv
module bbs_datapath #(
   parameter int MODULUS_WIDTH = bbs_pkg::MODULUS_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  bbs_pkg::csr_index_type                csr_index,
   input  logic [MODULUS_WIDTH-1:0]              csr_write_data,
   input  bbs_pkg::bbs_cmd_type                  cmd,
   output bbs_pkg::bbs_status_type               status,
   output logic                                  random_bit,
   output logic [bbs_pkg::STATE_VALUE_WIDTH-1:0] state_value
);

   localparam int ProdWidth = 2 * MODULUS_WIDTH;
   localparam int CntWidth  = $clog2(ProdWidth);

   logic [MODULUS_WIDTH-1:0] modulus_ff, modulus_in;
   logic [MODULUS_WIDTH-1:0] seed_ff, seed_in;
   logic [MODULUS_WIDTH-1:0] cur_ff, cur_in;
   logic [ProdWidth-1:0]     prod_ff, prod_in;
   logic [MODULUS_WIDTH-1:0] rem_ff, rem_in;
   logic [CntWidth-1:0]      cnt_ff, cnt_in;
   logic                     bit_ff, bit_in;
   logic [bbs_pkg::STATE_VALUE_WIDTH-1:0] value_ff, value_in;

   logic [MODULUS_WIDTH-1:0] operand;
   logic [MODULUS_WIDTH:0]   shifted;
   logic [MODULUS_WIDTH-1:0] result;

   assign operand = cmd.sel_seed ? seed_ff : cur_ff;
   assign shifted = {rem_ff, prod_ff[ProdWidth-1]};
   // a zero modulus reduces everything to zero
   assign result  = (modulus_ff == '0) ? '0 : rem_ff;

   assign status.red_last = (cnt_ff == CntWidth'(ProdWidth - 1));
   assign random_bit      = bit_ff;
   assign state_value     = value_ff;

   always_comb begin
      modulus_in = modulus_ff;
      seed_in    = seed_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            bbs_pkg::CSR_MODULUS: modulus_in = csr_write_data;
            bbs_pkg::CSR_SEED:    seed_in    = csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      cur_in   = cur_ff;
      bit_in   = bit_ff;
      value_in = value_ff;
      if (cmd.mul) begin
         prod_in = ProdWidth'(operand) * ProdWidth'(operand);
         rem_in  = '0;
         cnt_in  = '0;
      end
      if (cmd.red_step) begin
         // remainder stays below the modulus, so one subtract suffices
         prod_in = {prod_ff[ProdWidth-2:0], 1'b0};
         cnt_in  = cnt_ff + CntWidth'(1);
         if (shifted >= {1'b0, modulus_ff}) begin
            rem_in = MODULUS_WIDTH'(shifted - {1'b0, modulus_ff});
         end else begin
            rem_in = shifted[MODULUS_WIDTH-1:0];
         end
      end
      if (cmd.write_cur) begin
         cur_in = result;
      end
      if (cmd.out_load) begin
         bit_in   = result[0];
         value_in = bbs_pkg::STATE_VALUE_WIDTH'(result);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_WIDTH'(bbs_pkg::MODULUS_RESET);
         seed_ff    <= '0;
         cur_ff     <= '0;
      end else begin
         modulus_ff <= modulus_in;
         seed_ff    <= seed_in;
         cur_ff     <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      bit_ff   <= bit_in;
      value_ff <= value_in;
   end

endmodule

>>> rtl/bbs_random_bit_generator_unit.sv
// Channel  Direction  Payload
// req      in         restart
// rsp      out        random_bit, state_value
// csr      in         csr_write_enable, csr_index, csr_write_data
//
// An item runs from accept through the square and its reduction to the state write before the next accept;
// the reduction is a bit-serial shift-subtract of the square, one product bit a cycle.
// A restart item, and the first item after reset, squares twice before its result.
// Reset is synchronous and active high; modulus returns to 3, seed and state to 0.
// A result waits in the output register; a new item is accepted meanwhile and only
// its final write stalls until the output register is free.
module bbs_random_bit_generator_unit #(
   parameter int MODULUS_WIDTH = bbs_pkg::MODULUS_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   bbs_req_if.sink                  req_if,
   bbs_rsp_if.source                rsp_if,
   input  logic                     csr_write_enable,
   input  bbs_pkg::csr_index_type   csr_index,
   input  logic [MODULUS_WIDTH-1:0] csr_write_data
);

   bbs_pkg::bbs_cmd_type    cmd;
   bbs_pkg::bbs_status_type status;

   bbs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_restart (req_if.restart),
      .req_ready   (req_if.ready),
      .rsp_ready   (rsp_if.ready),
      .rsp_valid   (rsp_if.valid),
      .cmd         (cmd),
      .status      (status)
   );

   bbs_datapath #(
      .MODULUS_WIDTH (MODULUS_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .random_bit       (rsp_if.random_bit),
      .state_value      (rsp_if.state_value)
   );

endmodule

>>> tb/bbs_bit_checker.sv
`timescale 1ns / 1ps

module bbs_bit_checker (
   input  logic                   clock,
   input  logic                   reset,
   bbs_req_if                     req_if,
   bbs_rsp_if                     rsp_if,
   input  logic                   csr_write_enable,
   input  bbs_pkg::csr_index_type csr_index,
   input  logic [31:0]            csr_write_data,
   output int                     fail_count,
   output int                     pending_count
);

   typedef struct packed {
      logic                                  random_bit;
      logic [bbs_pkg::STATE_VALUE_WIDTH-1:0] state_value;
   } bbs_result_type;

   bbs_result_type pending_results[$];

   logic [31:0] modulus_reg;
   logic [31:0] seed_reg;
   logic [31:0] state_reg;
   logic        seeded_reg;

   // full 64-bit square reduced by n; a zero modulus reduces everything to zero
   function automatic logic [31:0] square_mod(input logic [31:0] x, input logic [31:0] n);
      logic [63:0] square;
      if (n == '0) return '0;
      square = {32'd0, x} * {32'd0, x};
      return 32'(square % {32'd0, n});
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      fail_count++;
      $display("%0t: %s: got %h, want %h", $time, what, got, want);
   endtask

   always @(posedge clock) begin
      bbs_result_type got;
      bbs_result_type want;
      if (reset) begin
         modulus_reg = 32'(bbs_pkg::MODULUS_RESET);
         seed_reg    = '0;
         state_reg   = '0;
         seeded_reg  = 1'b0;
         pending_results.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == bbs_pkg::CSR_MODULUS)
               modulus_reg = csr_write_data;
            else if (csr_index == bbs_pkg::CSR_SEED)
               seed_reg = csr_write_data;
         end

         if (rsp_if.valid && rsp_if.ready) begin
            got.random_bit  = rsp_if.random_bit;
            got.state_value = rsp_if.state_value;
            if (pending_results.size() == 0) begin
               report_mismatch("result with no item pending", got.state_value, '0);
            end else begin
               want = pending_results.pop_front();
               if (got.random_bit !== want.random_bit)
                  report_mismatch("random_bit", 32'(got.random_bit),
                                  32'(want.random_bit));
               if (got.state_value !== want.state_value)
                  report_mismatch("state_value", got.state_value, want.state_value);
            end
         end

         if (req_if.valid && req_if.ready) begin
            // reload from the seed on restart or on the first item after reset
            if (req_if.restart || !seeded_reg) begin
               state_reg  = square_mod(seed_reg, modulus_reg);
               seeded_reg = 1'b1;
            end
            state_reg        = square_mod(state_reg, modulus_reg);
            want.random_bit  = state_reg[0];
            want.state_value = state_reg;
            pending_results.push_back(want);
         end
      end
      pending_count = pending_results.size();
   end

endmodule

>>> tb/bbs_random_bit_generator_unit_test.sv
`timescale 1ns / 1ps

module bbs_random_bit_generator_unit_test;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_CYCLES = 400;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_enable;
   bbs_pkg::csr_index_type csr_index;
   logic [31:0]            csr_write_data;

   int fail_count;
   int pending_count;
   int cycle_count;
   bit quiet;
   bit hold_response;

   bbs_req_if req_chan ();
   bbs_rsp_if rsp_chan ();

   bbs_random_bit_generator_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_chan),
      .rsp_if           (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   bbs_bit_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_chan),
      .rsp_if           (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("bbs_random_bit_generator_unit: mismatch");
         $finish;
      end
   end

   task automatic send_item(input logic restart);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.restart <= restart;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // drop valid and wait until every item has come back
   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_regs(input logic [31:0] modulus_value,
                               input logic [31:0] seed_value);
      csr_write_enable <= 1'b1;
      csr_index        <= bbs_pkg::CSR_MODULUS;
      csr_write_data   <= modulus_value;
      @(posedge clock);
      csr_index        <= bbs_pkg::CSR_SEED;
      csr_write_data   <= seed_value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // result side
   initial begin
      int stall;
      bit held;
      held = 1'b0;
      rsp_chan.ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (hold_response && !held) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            held = 1'b1;
         end
         stall = quiet ? 0 : $urandom_range(0, 4);
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   initial begin
      int          phase;
      int          i;
      logic [31:0] modulus_value;
      logic [31:0] seed_value;
      bit          first_restart;
      bit          change_modulus;

      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.restart <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index        <= bbs_pkg::CSR_MODULUS;
      csr_write_data   <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset values: modulus 3, seed 0, unseeded state
      send_item(1'b0);
      send_item(1'b0);
      send_item(1'b1);
      settle();

      // zero and one moduli reduce everything to zero
      program_regs(32'd0, 32'h1234_5678);
      send_item(1'b1);
      send_item(1'b0);
      settle();
      program_regs(32'd1, 32'hFFFF_FFFF);
      send_item(1'b0);
      send_item(1'b1);
      settle();

      // widest operands
      program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFE);
      send_item(1'b1);
      send_item(1'b0);
      send_item(1'b0);
      settle();

      // seed far above the modulus
      program_regs(32'd77, 32'hFFFF_FFFF);
      send_item(1'b1);
      send_item(1'b0);
      send_item(1'b0);
      settle();

      // change the modulus mid-run, keep the state
      program_regs(32'd209, 32'd3);
      send_item(1'b1);
      send_item(1'b0);
      send_item(1'b0);
      settle();
      program_regs(32'hFFFF_FFFB, 32'd3);
      send_item(1'b0);
      send_item(1'b0);
      send_item(1'b0);
      settle();

      for (phase = 0; phase < 16; phase++) begin
         case ($urandom_range(0, 7))
            0:       modulus_value = $urandom_range(0, 1);
            1:       modulus_value = $urandom_range(3, 255);
            2:       modulus_value = '1;
            default: modulus_value = $urandom;
         endcase
         case ($urandom_range(0, 3))
            0:       seed_value = $urandom_range(0, 15);
            1:       seed_value = '1;
            default: seed_value = $urandom;
         endcase
         first_restart  = ($urandom_range(0, 3) != 0);
         change_modulus = ($urandom_range(0, 3) == 0);
         quiet          = ($urandom_range(0, 3) == 0);
         // fill the block while the result side holds off
         if (phase == 2)
            hold_response = 1'b1;
         program_regs(modulus_value, seed_value);
         for (i = 0; i < 100; i++) begin
            if (i == 50 && change_modulus) begin
               settle();
               program_regs($urandom, seed_value);
            end
            send_item(i == 0 ? first_restart : ($urandom_range(0, 15) == 0));
         end
         settle();
      end

      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("bbs_random_bit_generator_unit: match");
      else
         $display("bbs_random_bit_generator_unit: mismatch");
      $finish;
   end

endmodule
